[rtl/core/rdslot_pkg.sv]
package rdslot_pkg;

  // table geometry
  localparam int SLOTS = 16;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_W = 5;
  localparam int ADDR_W = 32;
  localparam int LEN_W = 31;

  // request codes
  typedef enum logic [2:0] {
    ACT_SUBMIT    = 3'd0,
    ACT_POLL      = 3'd1,
    ACT_CANCEL    = 3'd2,
    ACT_RESET_ALL = 3'd3,
    ACT_START     = 3'd4,
    ACT_COMPLETE  = 3'd5
  } action_t;

  // answer codes
  typedef enum logic [2:0] {
    ANS_OK      = 3'd0,
    ANS_PENDING = 3'd1,
    ANS_FAILED  = 3'd2,
    ANS_FULL    = 3'd3,
    ANS_INVALID = 3'd4,
    ANS_NONE    = 3'd5
  } answer_t;

  // slot status codes
  typedef enum logic [2:0] {
    ST_FREE      = 3'd0,
    ST_WAITING   = 3'd1,
    ST_BUSY      = 3'd2,
    ST_FINISHED  = 3'd3,
    ST_ERROR     = 3'd4,
    ST_RESETTING = 3'd5
  } status_t;

  // stored read descriptor
  typedef struct packed {
    logic [ADDR_W-1:0] file_id;
    logic [ADDR_W-1:0] file_offset;
    logic [ADDR_W-1:0] buffer_address;
    logic [LEN_W-1:0]  byte_count;
  } desc_t;

  // controller to datapath
  typedef struct packed {
    logic load_req;
    logic look;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_full;
  } sts_t;

endpackage

[rtl/core/rdslot_req_if.sv]
interface rdslot_req_if;
  import rdslot_pkg::*;

  logic              valid;
  logic              ready;
  logic [2:0]        action;
  logic [ADDR_W-1:0] file_id;
  logic [ADDR_W-1:0] file_offset;
  logic [ADDR_W-1:0] buffer_address;
  logic [LEN_W-1:0]  byte_count;
  logic [SLOT_W-1:0] slot_index;
  logic              read_ok;
  logic [LEN_W-1:0]  bytes_done;

  modport source (
    output valid, action, file_id, file_offset, buffer_address, byte_count,
           slot_index, read_ok, bytes_done,
    input  ready
  );

  modport sink (
    input  valid, action, file_id, file_offset, buffer_address, byte_count,
           slot_index, read_ok, bytes_done,
    output ready
  );

endinterface

[rtl/core/rdslot_rsp_if.sv]
interface rdslot_rsp_if;
  import rdslot_pkg::*;

  logic              valid;
  logic              ready;
  logic [2:0]        answer;
  logic [SLOT_W-1:0] slot_out;
  logic [ADDR_W-1:0] file_id_out;
  logic [ADDR_W-1:0] file_offset_out;
  logic [ADDR_W-1:0] buffer_address_out;
  logic [LEN_W-1:0]  byte_count_out;

  modport source (
    output valid, answer, slot_out, file_id_out, file_offset_out,
           buffer_address_out, byte_count_out,
    input  ready
  );

  modport sink (
    input  valid, answer, slot_out, file_id_out, file_offset_out,
           buffer_address_out, byte_count_out,
    output ready
  );

endinterface

[rtl/core/async_read_request_slot_table_top.sv]
// the result is registered through the lookup step and then the settle step
// a new request is taken only after the slot search with the registered descriptor
//   read and the settle step of the previous one, once ready comes back high
// the next request is taken while the previous result waits in the output register,
//   and its settle step stalls until that result is transferred
// reset (rst, synchronous): all slots free, no result pending, ready high
// descriptors hold no reset value and are written by submit before a read of them is used
module async_read_request_slot_table_top
  import rdslot_pkg::*;
(
  input logic clk,
  input logic rst,
  rdslot_req_if.sink   req,
  rdslot_rsp_if.source rsp
);

  cmd_t cmd;
  sts_t sts;

  // sequencing
  rdslot_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // slot table and result register
  rdslot_dp u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sts (sts),
    .req (req),
    .rsp (rsp)
  );

endmodule

[rtl/core/rdslot_ctrl.sv]
module rdslot_ctrl
  import rdslot_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_FIN
  } state_t;

  state_t state;

  // state and registered ready
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= S_LOOK;
            in_ready <= 1'b0;
          end
        end
        S_LOOK: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (!sts.out_full) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= S_IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

  // commands to the datapath
  always_comb begin
    cmd.load_req = in_valid && in_ready;
    cmd.look     = (state == S_LOOK);
    cmd.finish   = (state == S_FIN) && !sts.out_full;
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE)
    else $error("ready raised outside idle");

  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_LOOK)
    else $error("accepted request did not start lookup");

  a_look_fin: assert property (@(posedge clk) disable iff (rst)
    state == S_LOOK |=> state == S_FIN)
    else $error("lookup not followed by finish state");

endmodule

[rtl/core/rdslot_dp.sv]
module rdslot_dp
  import rdslot_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  output sts_t sts,
  rdslot_req_if.sink   req,
  rdslot_rsp_if.source rsp
);

  // latched request
  logic [2:0]        r_action;
  desc_t             r_desc;
  logic [SLOT_W-1:0] r_slot;
  logic              r_ok;
  logic [LEN_W-1:0]  r_done;

  // slot state and descriptor store
  status_t status [SLOTS];
  desc_t   mem    [SLOTS];
  desc_t   rd_data;

  // lookup results
  logic             free_hit;
  logic [IDX_W-1:0] free_idx;
  logic             wait_hit;
  logic [IDX_W-1:0] wait_idx;
  logic             hit;
  logic [IDX_W-1:0] sel;
  logic [IDX_W-1:0] rd_addr;

  // finish-step decode
  logic             idx_ok;
  logic [IDX_W-1:0] idx;
  status_t          cur;
  answer_t          ans;
  logic             st_we;
  logic [IDX_W-1:0] st_idx;
  status_t          st_val;
  logic             rst_all;
  logic             any_busy;

  // output register
  logic              out_valid;
  answer_t           out_answer;
  logic [SLOT_W-1:0] out_slot;
  desc_t             out_desc;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      r_action              <= req.action;
      r_desc.file_id        <= req.file_id;
      r_desc.file_offset    <= req.file_offset;
      r_desc.buffer_address <= req.buffer_address;
      r_desc.byte_count     <= req.byte_count;
      r_slot                <= req.slot_index;
      r_ok                  <= req.read_ok;
      r_done                <= req.bytes_done;
    end
  end

  // lowest free and lowest waiting slot
  always_comb begin
    free_hit = 1'b0;
    free_idx = '0;
    wait_hit = 1'b0;
    wait_idx = '0;
    any_busy = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (status[i] == ST_FREE) begin
        free_hit = 1'b1;
        free_idx = IDX_W'(i);
      end
      if (status[i] == ST_WAITING) begin
        wait_hit = 1'b1;
        wait_idx = IDX_W'(i);
      end
      if (status[i] == ST_BUSY) begin
        any_busy = 1'b1;
      end
    end
  end

  assign idx     = r_slot[IDX_W-1:0];
  assign idx_ok  = (r_slot < SLOT_W'(SLOTS));
  assign rd_addr = (r_action == ACT_START) ? wait_idx : idx;

  // lookup stage: register the chosen slot and read the descriptor of the waiting slot (start) or of the named slot
  always_ff @(posedge clk) begin
    if (cmd.look) begin
      hit     <= (r_action == ACT_SUBMIT) ? free_hit : wait_hit;
      sel     <= (r_action == ACT_SUBMIT) ? free_idx : wait_idx;
      rd_data <= mem[rd_addr];
    end
  end

  // descriptor write on submit
  always_ff @(posedge clk) begin
    if (cmd.finish && r_action == ACT_SUBMIT && hit) begin
      mem[sel] <= r_desc;
    end
  end

  assign cur = status[idx];

  // finish-step decision
  always_comb begin
    ans     = ANS_OK;
    st_we   = 1'b0;
    st_idx  = idx;
    st_val  = ST_FREE;
    rst_all = 1'b0;
    unique case (r_action)
      ACT_SUBMIT: begin
        if (!hit) begin
          ans = ANS_FULL;
        end else begin
          st_we  = 1'b1;
          st_idx = sel;
          st_val = ST_WAITING;
        end
      end
      ACT_POLL: begin
        if (!idx_ok) begin
          ans = ANS_INVALID;
        end else if (cur == ST_FINISHED || cur == ST_FREE) begin
          st_we = 1'b1;
        end else if (cur == ST_WAITING || cur == ST_BUSY) begin
          ans = ANS_PENDING;
        end else begin
          st_we = 1'b1;
          ans   = ANS_FAILED;
        end
      end
      ACT_CANCEL: begin
        if (!idx_ok) begin
          ans = ANS_INVALID;
        end else if (cur != ST_WAITING && cur != ST_BUSY) begin
          st_we = 1'b1;
        end
      end
      ACT_RESET_ALL: begin
        rst_all = 1'b1;
      end
      ACT_START: begin
        if (!hit) begin
          ans = ANS_NONE;
        end else begin
          st_we  = 1'b1;
          st_idx = sel;
          st_val = ST_BUSY;
        end
      end
      ACT_COMPLETE: begin
        if (!idx_ok) begin
          ans = ANS_INVALID;
        end else if (cur == ST_BUSY) begin
          st_we = 1'b1;
          if (r_ok && r_done == rd_data.byte_count) begin
            st_val = ST_FINISHED;
          end else begin
            st_val = ST_ERROR;
            ans    = ANS_FAILED;
          end
        end else if (cur == ST_RESETTING) begin
          st_we = 1'b1;
        end else begin
          ans = ANS_INVALID;
        end
      end
      default: begin
        ans = ANS_OK;
      end
    endcase
  end

  // slot status update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        status[i] <= ST_FREE;
      end
    end else if (cmd.finish) begin
      if (rst_all) begin
        for (int i = 0; i < SLOTS; i++) begin
          status[i] <= (status[i] == ST_BUSY) ? ST_RESETTING : ST_FREE;
        end
      end else if (st_we) begin
        status[st_idx] <= st_val;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_answer <= ans;
      out_slot   <= ((r_action == ACT_SUBMIT || r_action == ACT_START) && hit)
                    ? SLOT_W'(sel) : '0;
      out_desc   <= (r_action == ACT_START && hit) ? rd_data : '0;
    end
  end

  assign sts.out_full           = out_valid && !rsp.ready;
  assign rsp.valid              = out_valid;
  assign rsp.answer             = out_answer;
  assign rsp.slot_out           = out_slot;
  assign rsp.file_id_out        = out_desc.file_id;
  assign rsp.file_offset_out    = out_desc.file_offset;
  assign rsp.buffer_address_out = out_desc.buffer_address;
  assign rsp.byte_count_out     = out_desc.byte_count;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !(out_valid && !rsp.ready))
    else $error("result overwritten before transfer");

  a_submit_waits: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && r_action == ACT_SUBMIT && hit |=> status[$past(sel)] == ST_WAITING)
    else $error("submitted slot not marked waiting");

  a_reset_all_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && r_action == ACT_RESET_ALL |=> !any_busy)
    else $error("busy slot left after reset all");

endmodule
